/* hdl/bitmap_index_allocator_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap index allocator
// Concurrent assertion wrappers, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef BITMAP_INDEX_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_INDEX_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BIA_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define BIA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define BIA_ASSERT_SAME(label, clk, rstn, ante, cons)
`define BIA_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

/* hdl/bia_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap index allocator package
// Shared widths, codes, state type and controller/datapath structs.
// ----------------------------------------------------------------------------
package bia_pkg;

    localparam int CHUNKS   = 64;
    localparam int WORD_W   = 64;
    localparam int CHUNK_W  = 6;
    localparam int BIT_W    = 6;
    localparam int CNT_W    = 7;
    localparam int INDEX_W  = 12;
    localparam int RCOUNT_W = 13;
    localparam int TOTAL_W  = 13;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_RESERVE = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BAD    = 2'd2,
        ST_REJECT = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_A_RD,
        S_A_CHK,
        S_F_RD,
        S_F_CHK,
        S_R_RD,
        S_R_CHK,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_CFG,
        ACT_CAPTURE,
        ACT_DECODE,
        ACT_WRAP,
        ACT_ALLOC_CHK,
        ACT_FREE_CHK,
        ACT_RSV_CHK
    } action_t;

    typedef struct packed {
        action_t action;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    avail_zero;
        logic    free_oor;
        logic    rsv_ok;
        logic    cur_ge_avail;
        logic    word_nonzero;
        logic    word_all_ones;
        logic    last_chunk;
        logic    scan_done;
        logic    out_free;
    } dp_status_t;

endpackage

/* hdl/bitmap_index_allocator_core.sv */
`timescale 1ns / 1ps
// Sequence: a request settled at decode goes straight to the finish state; a free reads and checks
// its one chunk; a reserve of n chunks reads and checks them in turn; an allocate reads and checks
// chunks until one has a free bit, first wrapping a stale start chunk into range by subtraction.
// Requests: one at a time; the next is taken once the controller is back in idle after the result
// moves to the output register.
// Reset: synchronous, active low; all 64 chunks free, nothing used, no clearing pass.
// ----------------------------------------------------------------------------
// Bitmap index allocator core
// Next-fit index allocator over a free bitmap of 64-bit chunks, with free,
// double-free detection and chunk reservation from the top of the range.
// ----------------------------------------------------------------------------
`include "bitmap_index_allocator_core_assert.svh"

module bitmap_index_allocator_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    // request channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_opcode,
    input  logic [bia_pkg::INDEX_W-1:0]  s_free_index,
    input  logic [bia_pkg::RCOUNT_W-1:0] s_reserve_count,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bia_pkg::INDEX_W-1:0]  m_result_index,
    output logic [1:0]                   m_status,
    output logic [bia_pkg::TOTAL_W-1:0]  m_used_count,
    output logic [bia_pkg::CHUNK_W-1:0]  m_highest_chunk_seen,
    // chunk_count register write
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bia_pkg::CNT_W-1:0]    cfg_chunk_count
);

    bia_pkg::dp_cmd_t    dp_cmd;
    bia_pkg::dp_status_t dp_status;

    // The controller walks each request through decode, one memory read per
    // chunk and a check/update step; the datapath owns the free map, the
    // chunk valid bits that stand in for a refill sweep, and the counters.
    bia_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    // The result register decouples the two sides: a finished result waits
    // there while the controller returns to idle and takes the next request.
    bia_datapath u_datapath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .dp_cmd               (dp_cmd),
        .dp_status            (dp_status),
        .s_opcode             (s_opcode),
        .s_free_index         (s_free_index),
        .s_reserve_count      (s_reserve_count),
        .cfg_chunk_count      (cfg_chunk_count),
        .m_ready              (m_ready),
        .m_valid              (m_valid),
        .m_result_index       (m_result_index),
        .m_status             (m_status),
        .m_used_count         (m_used_count),
        .m_highest_chunk_seen (m_highest_chunk_seen)
    );

    // one request in flight: an accepted request holds off the next one
    `BIA_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)

    // any failing status carries index zero
    `BIA_ASSERT_SAME(a_fail_index_zero, aclk, aresetn, m_valid && (m_status != bia_pkg::ST_OK), m_result_index == '0)

    // the used count never exceeds the pool capacity
    `BIA_ASSERT_SAME(a_used_bounded, aclk, aresetn, m_valid, m_used_count <= bia_pkg::TOTAL_W'(bia_pkg::CHUNKS * bia_pkg::WORD_W))

    // a loaded result always shows up on the port in the next cycle
    `BIA_ASSERT_NEXT(a_result_visible, aclk, aresetn, dp_cmd.load_out, m_valid)

endmodule

/* hdl/bia_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap index allocator controller
// Sequences decode, chunk reads, checks and result hand-off.
// ----------------------------------------------------------------------------
module bia_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  bia_pkg::dp_status_t dp_status,
    output bia_pkg::dp_cmd_t    dp_cmd
);

    bia_pkg::state_t state_reg;
    bia_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bia_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        dp_cmd.action   = bia_pkg::ACT_NONE;
        dp_cmd.load_out = 1'b0;
        s_ready         = 1'b0;
        cfg_ready       = 1'b0;
        unique case (state_reg)
            bia_pkg::S_IDLE: begin
                cfg_ready = 1'b1;
                s_ready   = !cfg_valid;
                if (cfg_valid) begin
                    dp_cmd.action = bia_pkg::ACT_CFG;
                end else if (s_valid) begin
                    dp_cmd.action = bia_pkg::ACT_CAPTURE;
                    state_next    = bia_pkg::S_DECODE;
                end
            end
            bia_pkg::S_DECODE: begin
                dp_cmd.action = bia_pkg::ACT_DECODE;
                unique case (dp_status.op)
                    bia_pkg::OP_ALLOC: begin
                        state_next = dp_status.avail_zero ? bia_pkg::S_FINISH : bia_pkg::S_A_RD;
                    end
                    bia_pkg::OP_FREE: begin
                        state_next = dp_status.free_oor ? bia_pkg::S_FINISH : bia_pkg::S_F_RD;
                    end
                    bia_pkg::OP_RESERVE: begin
                        state_next = dp_status.rsv_ok ? bia_pkg::S_R_RD : bia_pkg::S_FINISH;
                    end
                    default: begin
                        state_next = bia_pkg::S_FINISH;
                    end
                endcase
            end
            bia_pkg::S_A_RD: begin
                // wrap a stale start chunk, then let the read settle
                dp_cmd.action = bia_pkg::ACT_WRAP;
                if (!dp_status.cur_ge_avail) begin
                    state_next = bia_pkg::S_A_CHK;
                end
            end
            bia_pkg::S_A_CHK: begin
                dp_cmd.action = bia_pkg::ACT_ALLOC_CHK;
                if (dp_status.word_nonzero || dp_status.scan_done) begin
                    state_next = bia_pkg::S_FINISH;
                end else begin
                    state_next = bia_pkg::S_A_RD;
                end
            end
            bia_pkg::S_F_RD: begin
                state_next = bia_pkg::S_F_CHK;
            end
            bia_pkg::S_F_CHK: begin
                dp_cmd.action = bia_pkg::ACT_FREE_CHK;
                state_next    = bia_pkg::S_FINISH;
            end
            bia_pkg::S_R_RD: begin
                state_next = bia_pkg::S_R_CHK;
            end
            bia_pkg::S_R_CHK: begin
                dp_cmd.action = bia_pkg::ACT_RSV_CHK;
                if (!dp_status.word_all_ones || dp_status.last_chunk) begin
                    state_next = bia_pkg::S_FINISH;
                end else begin
                    state_next = bia_pkg::S_R_RD;
                end
            end
            bia_pkg::S_FINISH: begin
                if (dp_status.out_free) begin
                    dp_cmd.load_out = 1'b1;
                    state_next      = bia_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bia_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/bia_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap index allocator datapath
// Free map memory, chunk valid bits, counters and the result register.
// ----------------------------------------------------------------------------
module bia_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bia_pkg::dp_cmd_t                    dp_cmd,
    output bia_pkg::dp_status_t                 dp_status,
    input  logic [1:0]                          s_opcode,
    input  logic [bia_pkg::INDEX_W-1:0]         s_free_index,
    input  logic [bia_pkg::RCOUNT_W-1:0]        s_reserve_count,
    input  logic [bia_pkg::CNT_W-1:0]           cfg_chunk_count,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [bia_pkg::INDEX_W-1:0]         m_result_index,
    output logic [1:0]                          m_status,
    output logic [bia_pkg::TOTAL_W-1:0]         m_used_count,
    output logic [bia_pkg::CHUNK_W-1:0]         m_highest_chunk_seen
);

    // free map: one word per chunk, set bit = free
    logic [bia_pkg::WORD_W-1:0]   mem [bia_pkg::CHUNKS];
    logic [bia_pkg::WORD_W-1:0]   rd_data_reg;
    logic                         rd_known_reg;
    logic                         rd_inrange_reg;
    logic [bia_pkg::CHUNKS-1:0]   known_reg;

    logic [bia_pkg::CNT_W-1:0]    chunk_count_reg;
    logic [bia_pkg::CNT_W-1:0]    avail_reg;
    logic [bia_pkg::CHUNK_W-1:0]  hint_reg;
    logic [bia_pkg::CHUNK_W-1:0]  max_reg;
    logic [bia_pkg::TOTAL_W-1:0]  total_reg;

    bia_pkg::opcode_t             op_reg;
    logic [bia_pkg::INDEX_W-1:0]  fidx_reg;
    logic [bia_pkg::RCOUNT_W-1:0] rcount_reg;
    logic [bia_pkg::CHUNK_W-1:0]  cur_reg;
    logic [bia_pkg::CNT_W-1:0]    k_reg;
    logic [bia_pkg::INDEX_W-1:0]  res_index_reg;
    bia_pkg::status_t             res_status_reg;

    logic                         m_valid_reg;
    logic [bia_pkg::INDEX_W-1:0]  m_index_reg;
    bia_pkg::status_t             m_status_reg;
    logic [bia_pkg::TOTAL_W-1:0]  m_used_reg;
    logic [bia_pkg::CHUNK_W-1:0]  m_high_reg;

    logic [bia_pkg::WORD_W-1:0]   cur_word;
    logic [bia_pkg::WORD_W-1:0]   low_onehot;
    logic [bia_pkg::BIT_W-1:0]    low_bit;
    logic [bia_pkg::WORD_W-1:0]   free_mask;
    logic [bia_pkg::CNT_W-1:0]    cur_ext;
    logic [bia_pkg::CNT_W-1:0]    cur_inc;
    logic [bia_pkg::CNT_W-1:0]    cur_wrapped;
    logic [bia_pkg::CHUNK_W-1:0]  fidx_chunk;
    logic [bia_pkg::CNT_W-1:0]    rsv_n;
    logic [bia_pkg::CNT_W-1:0]    rsv_first;
    logic [bia_pkg::CNT_W-1:0]    cfg_n;
    logic                         mem_we;
    logic [bia_pkg::WORD_W-1:0]   mem_wdata;

    function automatic logic [bia_pkg::BIT_W-1:0] encode_onehot(
        input logic [bia_pkg::WORD_W-1:0] oh
    );
        logic [bia_pkg::BIT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < bia_pkg::WORD_W; i++) begin
            if (oh[i]) begin
                idx = idx | bia_pkg::BIT_W'(i);
            end
        end
        return idx;
    endfunction

    // an entry never written since refill reads as its refill value
    assign cur_word    = rd_known_reg ? rd_data_reg : (rd_inrange_reg ? '1 : '0);
    assign low_onehot  = cur_word & (~cur_word + bia_pkg::WORD_W'(1));
    assign low_bit     = encode_onehot(low_onehot);
    assign free_mask   = bia_pkg::WORD_W'(1) << fidx_reg[bia_pkg::BIT_W-1:0];
    assign fidx_chunk  = fidx_reg[bia_pkg::INDEX_W-1:bia_pkg::BIT_W];
    assign cur_ext     = {1'b0, cur_reg};
    assign cur_inc     = cur_ext + bia_pkg::CNT_W'(1);
    assign cur_wrapped = cur_ext - avail_reg;
    assign rsv_n       = rcount_reg[bia_pkg::RCOUNT_W-1:bia_pkg::BIT_W];
    assign rsv_first   = avail_reg - rsv_n;

    always_comb begin
        if (cfg_chunk_count == '0) begin
            cfg_n = bia_pkg::CNT_W'(1);
        end else if (cfg_chunk_count > bia_pkg::CNT_W'(bia_pkg::CHUNKS)) begin
            cfg_n = bia_pkg::CNT_W'(bia_pkg::CHUNKS);
        end else begin
            cfg_n = cfg_chunk_count;
        end
    end

    always_comb begin
        dp_status.op            = op_reg;
        dp_status.avail_zero    = (avail_reg == '0);
        dp_status.free_oor      = ({1'b0, fidx_chunk} >= chunk_count_reg);
        dp_status.rsv_ok        = (rcount_reg[bia_pkg::BIT_W-1:0] == '0) && (rsv_n != '0)
                                  && (rsv_n <= avail_reg);
        dp_status.cur_ge_avail  = (cur_ext >= avail_reg);
        dp_status.word_nonzero  = (cur_word != '0);
        dp_status.word_all_ones = (cur_word == '1);
        dp_status.last_chunk    = (cur_inc == avail_reg);
        dp_status.scan_done     = ((k_reg + bia_pkg::CNT_W'(1)) == avail_reg);
        dp_status.out_free      = !m_valid_reg || m_ready;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = cur_word;
        if (dp_cmd.action == bia_pkg::ACT_ALLOC_CHK && cur_word != '0) begin
            mem_we    = 1'b1;
            mem_wdata = cur_word & ~low_onehot;
        end else if (dp_cmd.action == bia_pkg::ACT_FREE_CHK && (cur_word & free_mask) == '0) begin
            mem_we    = 1'b1;
            mem_wdata = cur_word | free_mask;
        end
    end

    // memory port: read every cycle at the current chunk, write on update
    always_ff @(posedge aclk) begin
        rd_data_reg    <= mem[cur_reg];
        rd_known_reg   <= known_reg[cur_reg];
        rd_inrange_reg <= (cur_ext < chunk_count_reg);
        if (mem_we) begin
            mem[cur_reg] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            known_reg       <= '0;
            chunk_count_reg <= bia_pkg::CNT_W'(bia_pkg::CHUNKS);
            avail_reg       <= bia_pkg::CNT_W'(bia_pkg::CHUNKS);
            hint_reg        <= '0;
            max_reg         <= '0;
            total_reg       <= '0;
            op_reg          <= bia_pkg::OP_NONE;
            fidx_reg        <= '0;
            rcount_reg      <= '0;
            cur_reg         <= '0;
            k_reg           <= '0;
            res_index_reg   <= '0;
            res_status_reg  <= bia_pkg::ST_OK;
        end else begin
            case (dp_cmd.action)
                bia_pkg::ACT_CFG: begin
                    known_reg       <= '0;
                    chunk_count_reg <= cfg_n;
                    avail_reg       <= cfg_n;
                    hint_reg        <= '0;
                    max_reg         <= '0;
                    total_reg       <= '0;
                end
                bia_pkg::ACT_CAPTURE: begin
                    op_reg         <= bia_pkg::opcode_t'(s_opcode);
                    fidx_reg       <= s_free_index;
                    rcount_reg     <= s_reserve_count;
                    cur_reg        <= hint_reg;
                    k_reg          <= '0;
                    res_index_reg  <= '0;
                    res_status_reg <= bia_pkg::ST_OK;
                end
                bia_pkg::ACT_DECODE: begin
                    case (op_reg)
                        bia_pkg::OP_ALLOC: begin
                            if (dp_status.avail_zero) begin
                                res_status_reg <= bia_pkg::ST_FULL;
                            end
                        end
                        bia_pkg::OP_FREE: begin
                            if (dp_status.free_oor) begin
                                res_status_reg <= bia_pkg::ST_BAD;
                            end else begin
                                cur_reg <= fidx_chunk;
                            end
                        end
                        bia_pkg::OP_RESERVE: begin
                            if (dp_status.rsv_ok) begin
                                cur_reg <= rsv_first[bia_pkg::CHUNK_W-1:0];
                            end else begin
                                res_status_reg <= bia_pkg::ST_REJECT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                bia_pkg::ACT_WRAP: begin
                    if (dp_status.cur_ge_avail) begin
                        cur_reg <= cur_wrapped[bia_pkg::CHUNK_W-1:0];
                    end
                end
                bia_pkg::ACT_ALLOC_CHK: begin
                    if (k_reg != '0 && cur_reg > max_reg) begin
                        max_reg <= cur_reg;
                    end
                    if (dp_status.word_nonzero) begin
                        known_reg[cur_reg] <= 1'b1;
                        hint_reg           <= cur_reg;
                        total_reg          <= total_reg + bia_pkg::TOTAL_W'(1);
                        res_index_reg      <= {cur_reg, low_bit};
                    end else if (dp_status.scan_done) begin
                        res_status_reg <= bia_pkg::ST_FULL;
                    end else begin
                        k_reg   <= k_reg + bia_pkg::CNT_W'(1);
                        cur_reg <= dp_status.last_chunk ? '0 : cur_inc[bia_pkg::CHUNK_W-1:0];
                    end
                end
                bia_pkg::ACT_FREE_CHK: begin
                    if ((cur_word & free_mask) != '0) begin
                        res_status_reg <= bia_pkg::ST_BAD;
                    end else begin
                        known_reg[cur_reg] <= 1'b1;
                        if (total_reg != '0) begin
                            total_reg <= total_reg - bia_pkg::TOTAL_W'(1);
                        end
                    end
                end
                bia_pkg::ACT_RSV_CHK: begin
                    if (!dp_status.word_all_ones) begin
                        res_status_reg <= bia_pkg::ST_REJECT;
                    end else if (dp_status.last_chunk) begin
                        avail_reg     <= rsv_first;
                        res_index_reg <= {rsv_first[bia_pkg::CHUNK_W-1:0],
                                          bia_pkg::BIT_W'(0)};
                    end else begin
                        cur_reg <= cur_inc[bia_pkg::CHUNK_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (dp_cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.load_out) begin
            m_index_reg  <= res_index_reg;
            m_status_reg <= res_status_reg;
            m_used_reg   <= total_reg;
            m_high_reg   <= max_reg;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_result_index       = m_index_reg;
    assign m_status             = m_status_reg;
    assign m_used_count         = m_used_reg;
    assign m_highest_chunk_seen = m_high_reg;

endmodule
